### design/idq_pkg.sv
package idq_pkg;

  localparam int CAPACITY  = 256;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4,
    OP_WRITE      = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [7:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic [8:0]         element_count;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
  } idq_cmd_t;

endpackage

### design/indexed_double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words held in a circular buffer.
// A request is presented on in_item together with start and is taken at a
// rising edge where start is high and busy is low. The operation field picks
// push front, push back, pop front, pop back, read by index or write by index;
// position is the logical index from the front for read and write.
// Every request yields exactly one result on out_item, marked by out_strobe
// for a single cycle: the word read or popped (zero otherwise), the count
// after the operation and a status code (ok, full, empty, index out of range).
// A failing request leaves the queue untouched.
// The result is strobed in the response state that follows the execute state,
// and busy stays high until then, so a new request is not taken before the
// result of the last one. That pace is set by the single port of the word
// memory, whose read data is registered before it reaches the result.
// Reset empties the queue at once (front and count cleared); the word memory
// itself is not cleared, since only slots that were pushed are ever read.
// The receiver cannot stall: out_item holds a result only until the next request executes.
module indexed_double_ended_queue
  import idq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  idq_cmd_t cmd;

  idq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  idq_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

### design/idq_ctrl.sv
module idq_ctrl
  import idq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_strobe,
  output idq_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    busy       = 1'b1;
    out_strobe = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        out_strobe = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### design/idq_datapath.sv
module idq_datapath
  import idq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  idq_cmd_t  cmd,
  input  in_item_t  in_item,
  output out_item_t out_item
);

  in_item_t             req_r;
  logic [ADDR_W-1:0]    front_r, front_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [1:0]           status_r, status_nxt;
  logic                 sel_data_r, sel_data_nxt;
  logic [WORD_BITS-1:0] rdata_r;
  logic [WORD_BITS-1:0] mem [CAPACITY];

  logic                 mem_we, mem_re;
  logic [ADDR_W-1:0]    mem_addr;
  logic                 is_full, is_empty, in_range;
  logic [ADDR_W-1:0]    front_dec, front_inc;
  logic [ADDR_W-1:0]    slot_back, slot_last, slot_pos;

  // Physical slot of a logical index; the sum stays below twice the capacity.
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] front,
                                                input logic [ADDR_W-1:0] logical);
    logic [ADDR_W:0] sum;
    sum = {1'b0, front} + {1'b0, logical};
    if (sum >= (ADDR_W+1)'(CAPACITY)) begin
      sum = sum - (ADDR_W+1)'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign is_empty  = (count_r == '0);
  assign in_range  = (CNT_W'(req_r.position) < count_r);
  assign front_dec = (front_r == '0) ? ADDR_W'(CAPACITY - 1) : front_r - 1'b1;
  assign front_inc = (front_r == ADDR_W'(CAPACITY - 1)) ? '0 : front_r + 1'b1;
  assign slot_back = slot_of(front_r, count_r[ADDR_W-1:0]);
  assign slot_last = slot_of(front_r, ADDR_W'(count_r - 1'b1));
  assign slot_pos  = slot_of(front_r, ADDR_W'(req_r.position));

  always_comb begin
    front_nxt    = front_r;
    count_nxt    = count_r;
    status_nxt   = STAT_OK;
    sel_data_nxt = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = slot_pos;
    case (req_r.operation)
      OP_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = STAT_FULL;
        end else begin
          mem_we    = 1'b1;
          mem_addr  = front_dec;
          front_nxt = front_dec;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = STAT_FULL;
        end else begin
          mem_we    = 1'b1;
          mem_addr  = slot_back;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          mem_re       = 1'b1;
          sel_data_nxt = 1'b1;
          mem_addr     = front_r;
          front_nxt    = front_inc;
          count_nxt    = count_r - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (is_empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          mem_re       = 1'b1;
          sel_data_nxt = 1'b1;
          mem_addr     = slot_last;
          count_nxt    = count_r - 1'b1;
        end
      end
      OP_READ: begin
        if (!in_range) begin
          status_nxt = STAT_RANGE;
        end else begin
          mem_re       = 1'b1;
          sel_data_nxt = 1'b1;
        end
      end
      OP_WRITE: begin
        if (!in_range) begin
          status_nxt = STAT_RANGE;
        end else begin
          mem_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_item;
    end
    if (cmd.exec) begin
      status_r   <= status_nxt;
      sel_data_r <= sel_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[mem_addr] <= req_r.value[WORD_BITS-1:0];
    end
    if (cmd.exec && mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  always_comb begin
    out_item.data_out      = sel_data_r ? 32'(signed'(rdata_r)) : '0;
    out_item.element_count = 9'(count_r);
    out_item.status        = status_r;
  end

endmodule

### design/idq_checker.sv
module idq_checker
  import idq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input out_item_t out_item
);

  // Every accepted request gets its result strobe, after the execute state.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("request accepted without a result two cycles later");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after a request was accepted");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status != STAT_OK) |-> (out_item.data_out == '0))
    else $error("failed request returned nonzero data");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.element_count <= 9'(CAPACITY)))
    else $error("element count beyond capacity");

endmodule

bind indexed_double_ended_queue idq_checker u_idq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
